/* rtl/gbn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the go-back-n sender window block.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int SEQ_W     = 16;
  localparam int WIN_W     = 7;
  localparam int IDX_W     = 7;
  localparam int CNT_W     = 3;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 16;
  localparam int UPC_W     = 4;

  // cap on the window from the result count of one run
  localparam int WIN_HW_MAX = 64;

  // command opcodes
  localparam logic [OP_W-1:0] OP_START   = 2'd0;
  localparam logic [OP_W-1:0] OP_ACK     = 2'd1;
  localparam logic [OP_W-1:0] OP_TIMEOUT = 2'd2;
  localparam logic [OP_W-1:0] OP_RSVD    = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_SEND   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LIMIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 1'd1;

  localparam logic [WIN_W-1:0] WINDOW_LIMIT_RST  = 7'd8;
  localparam logic [SEQ_W-1:0] TOTAL_PACKETS_RST = 16'd1;

  // a packet already sent more than this many times aborts the transfer
  localparam logic [CNT_W-1:0] SEND_LIMIT = 3'd5;

  // microprogram step addresses
  localparam logic [UPC_W-1:0] ST_FETCH  = 4'd0;
  localparam logic [UPC_W-1:0] ST_DECODE = 4'd1;
  localparam logic [UPC_W-1:0] ST_ACK    = 4'd2;
  localparam logic [UPC_W-1:0] ST_START  = 4'd3;
  localparam logic [UPC_W-1:0] ST_ROUND  = 4'd4;
  localparam logic [UPC_W-1:0] ST_SLOT   = 4'd5;
  localparam logic [UPC_W-1:0] ST_TEST   = 4'd6;
  localparam logic [UPC_W-1:0] ST_SEND   = 4'd7;
  localparam logic [UPC_W-1:0] ST_RETURN = 4'd8;
  localparam logic [UPC_W-1:0] ST_ERROR  = 4'd9;
  localparam logic [UPC_W-1:0] ST_FINISH = 4'd10;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'b0001,
    PH_SENDING  = 4'b0010,
    PH_DONE     = 4'b0100,
    PH_STOPPED  = 4'b1000
  } phase_t;

  typedef enum logic [2:0] {
    DP_NONE,
    DP_ACK,
    DP_START,
    DP_ROUND,
    DP_SLOT,
    DP_SEND,
    DP_ERROR,
    DP_FINISH
  } dp_op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_IGNORE,
    C_IS_START,
    C_TOTAL_ZERO,
    C_NONE_LEFT,
    C_OVER,
    C_MORE
  } cond_t;

  typedef struct packed {
    logic             accept;
    logic             emit;
    dp_op_t           op;
    cond_t            cond;
    logic [UPC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic ignore;
    logic is_start;
    logic total_zero;
    logic none_left;
    logic over;
    logic more;
  } status_t;

endpackage
`default_nettype wire

/* rtl/gbn_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface gbn_cmd_if import gbn_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [SEQ_W-1:0] ack_number;

  modport source (output valid, output opcode, output ack_number, input ready);
  modport sink   (input valid, input opcode, input ack_number, output ready);
endinterface

interface gbn_res_if import gbn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SEQ_W-1:0]  seq_number;
  logic [SEQ_W-1:0]  window_base;
  logic [WIN_W-1:0]  window_now;
  logic              last_of_run;

  modport source (output valid, output kind, output seq_number, output window_base,
                  output window_now, output last_of_run, input ready);
  modport sink   (input valid, input kind, input seq_number, input window_base,
                  input window_now, input last_of_run, output ready);
endinterface

interface gbn_cfg_if import gbn_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* rtl/gbn_sequencer.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_sequencer
// Step counter and control store; one control word per step, conditional jumps.
// ----------------------------------------------------------------------------
module gbn_sequencer import gbn_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire status_t   st,
  output      ctl_word_t ctl,
  output      logic      go
);

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             taken;

  // control store
  always_comb begin
    ctl = '{accept: 1'b0, emit: 1'b0, op: DP_NONE, cond: C_ALWAYS, target: ST_FETCH};
    unique case (upc)
      ST_FETCH:  ctl = '{1'b1, 1'b0, DP_NONE,   C_IGNORE,     ST_FETCH};
      ST_DECODE: ctl = '{1'b0, 1'b0, DP_NONE,   C_IS_START,   ST_START};
      ST_ACK:    ctl = '{1'b0, 1'b0, DP_ACK,    C_ALWAYS,     ST_ROUND};
      ST_START:  ctl = '{1'b0, 1'b0, DP_START,  C_TOTAL_ZERO, ST_ERROR};
      ST_ROUND:  ctl = '{1'b0, 1'b0, DP_ROUND,  C_NONE_LEFT,  ST_FINISH};
      ST_SLOT:   ctl = '{1'b0, 1'b0, DP_SLOT,   C_NEVER,      ST_FETCH};
      ST_TEST:   ctl = '{1'b0, 1'b0, DP_NONE,   C_OVER,       ST_ERROR};
      ST_SEND:   ctl = '{1'b0, 1'b1, DP_SEND,   C_MORE,       ST_SLOT};
      ST_RETURN: ctl = '{1'b0, 1'b0, DP_NONE,   C_ALWAYS,     ST_FETCH};
      ST_ERROR:  ctl = '{1'b0, 1'b1, DP_ERROR,  C_ALWAYS,     ST_FETCH};
      ST_FINISH: ctl = '{1'b0, 1'b1, DP_FINISH, C_ALWAYS,     ST_FETCH};
      default:   ctl = '{1'b0, 1'b0, DP_NONE,   C_ALWAYS,     ST_FETCH};
    endcase
  end

  // a step waits for an input request or for room in the output register
  assign go = (!ctl.accept || st.in_valid) && (!ctl.emit || st.out_free);

  always_comb begin
    unique case (ctl.cond)
      C_NEVER:      taken = 1'b0;
      C_ALWAYS:     taken = 1'b1;
      C_IGNORE:     taken = st.ignore;
      C_IS_START:   taken = st.is_start;
      C_TOTAL_ZERO: taken = st.total_zero;
      C_NONE_LEFT:  taken = st.none_left;
      C_OVER:       taken = st.over;
      C_MORE:       taken = st.more;
      default:      taken = 1'b0;
    endcase
  end

  always_comb begin
    upc_next = upc;
    if (go) begin
      upc_next = taken ? ctl.target : upc + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= ST_FETCH;
    end else begin
      upc <= upc_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/gbn_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbn_datapath
// Window registers, send count memory, config registers and result register.
// ----------------------------------------------------------------------------
module gbn_datapath import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input  wire logic      clk,
  input  wire logic      rst,
  gbn_cmd_if.sink        cmd,
  gbn_res_if.source      res,
  gbn_cfg_if.sink        cfg,
  input  wire ctl_word_t ctl,
  input  wire logic      go,
  output      status_t   st
);

  localparam int WIN_CAP   = (WINDOW_MAX < WIN_HW_MAX) ? WINDOW_MAX : WIN_HW_MAX;
  localparam int SLOT_BITS = $clog2(WIN_CAP);
  localparam int DEPTH     = 1 << SLOT_BITS;

  // config registers
  logic [WIN_W-1:0] window_limit;
  logic [SEQ_W-1:0] total_packets;

  // transfer state
  phase_t           phase;
  logic [SEQ_W-1:0] oldest_unacked;
  logic [WIN_W-1:0] window_current;
  logic [SEQ_W-1:0] never_sent_from;
  logic [IDX_W-1:0] idx;
  logic [SEQ_W-1:0] seq_cur;
  logic             fresh;
  logic [OP_W-1:0]  op_q;
  logic [SEQ_W-1:0] ack_q;

  // send counts, live only for sequence numbers in the window
  logic [CNT_W-1:0] counts [DEPTH];
  logic [CNT_W-1:0] rdata;

  logic [SEQ_W-1:0] seq_calc;
  logic [CNT_W-1:0] count_now;
  logic [SEQ_W:0]   ack_plus;
  logic [SEQ_W-1:0] new_base;
  logic [SEQ_W-1:0] left;
  logic [WIN_W-1:0] win_start;
  logic             out_valid;

  assign cmd.ready = ctl.accept && !rst;
  assign cfg.ready = !rst;
  assign res.valid = out_valid;

  assign seq_calc  = oldest_unacked + SEQ_W'(idx);
  assign count_now = fresh ? '0 : rdata;
  assign ack_plus  = {1'b0, ack_q} + (SEQ_W + 1)'(1);
  assign new_base  = (ack_plus > {1'b0, total_packets}) ? total_packets : ack_plus[SEQ_W-1:0];
  assign left      = total_packets - oldest_unacked;

  always_comb begin
    if (window_limit == '0) begin
      win_start = WIN_W'(1);
    end else if (window_limit > WIN_W'(WIN_CAP)) begin
      win_start = WIN_W'(WIN_CAP);
    end else begin
      win_start = window_limit;
    end
  end

  always_comb begin
    st.in_valid   = cmd.valid;
    st.out_free   = !out_valid || res.ready;
    st.ignore     = (cmd.opcode == OP_RSVD) ||
                    ((cmd.opcode != OP_START) && (phase != PH_SENDING));
    st.is_start   = (op_q == OP_START);
    st.total_zero = (total_packets == '0);
    st.none_left  = (total_packets <= oldest_unacked);
    st.over       = (count_now > SEND_LIMIT);
    st.more       = ((idx + IDX_W'(1)) != IDX_W'(window_current));
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_limit  <= WINDOW_LIMIT_RST;
      total_packets <= TOTAL_PACKETS_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WINDOW_LIMIT:  window_limit  <= cfg.data[WIN_W-1:0];
        REG_TOTAL_PACKETS: total_packets <= cfg.data[SEQ_W-1:0];
        default: ;
      endcase
    end
  end

  // send count memory
  always_ff @(posedge clk) begin
    if (go && ctl.op == DP_SLOT) begin
      rdata <= counts[seq_calc[SLOT_BITS-1:0]];
    end
    if (go && ctl.op == DP_SEND) begin
      counts[seq_cur[SLOT_BITS-1:0]] <= count_now + CNT_W'(1);
    end
  end

  // window state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      oldest_unacked  <= '0;
      never_sent_from <= '0;
      window_current  <= '0;
    end else if (go) begin
      case (ctl.op)
        DP_START: begin
          window_current  <= win_start;
          oldest_unacked  <= '0;
          never_sent_from <= '0;
          phase           <= PH_SENDING;
        end
        DP_ACK: begin
          // stale acks and timeouts leave the base alone
          if (op_q == OP_ACK && ack_q >= oldest_unacked && new_base > oldest_unacked) begin
            oldest_unacked <= new_base;
          end
        end
        DP_ROUND: begin
          // the finish record keeps the window of the last round
          if (!st.none_left && left < SEQ_W'(window_current)) begin
            window_current <= left[WIN_W-1:0];
          end
        end
        DP_SLOT: begin
          if (seq_calc >= never_sent_from) begin
            never_sent_from <= seq_calc + SEQ_W'(1);
          end
        end
        DP_ERROR:  phase <= PH_STOPPED;
        DP_FINISH: phase <= PH_DONE;
        default: ;
      endcase
    end
  end

  // per-step scratch registers
  always_ff @(posedge clk) begin
    if (go && ctl.accept) begin
      op_q  <= cmd.opcode;
      ack_q <= cmd.ack_number;
    end
    if (go && ctl.op == DP_ROUND) begin
      idx <= '0;
    end else if (go && ctl.op == DP_SEND) begin
      idx <= idx + IDX_W'(1);
    end
    if (go && ctl.op == DP_SLOT) begin
      seq_cur <= seq_calc;
      fresh   <= (seq_calc >= never_sent_from);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (go && ctl.emit) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go && ctl.emit) begin
      res.window_base <= oldest_unacked;
      res.window_now  <= window_current;
      unique case (ctl.op)
        DP_SEND: begin
          res.kind        <= KIND_SEND;
          res.seq_number  <= seq_cur;
          res.last_of_run <= !st.more;
        end
        DP_FINISH: begin
          res.kind        <= KIND_FINISH;
          res.seq_number  <= '0;
          res.last_of_run <= 1'b1;
        end
        default: begin
          res.kind        <= KIND_ERROR;
          res.seq_number  <= '0;
          res.last_of_run <= 1'b1;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/go_back_n_sender_window_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_window_top
// Go-back-n sender window control driven by a small microcoded sequencer.
// ----------------------------------------------------------------------------
// result path: a taken request passes the fetch and decode steps, then the start
//   and error steps for an empty-transfer error, the ack, round and finish steps
//   for a finish, or the start or ack step and the round, slot read, count test
//   and send steps for the first data send; each further data send of a round
//   loops through the slot read, count test and send steps, no new request is taken
//   before the round ends, and a full result register holds the send step
// reset: synchronous rst; window_limit 8, total_packets 1, phase idle, no
//   clearing pass (counts are cleared as sequence numbers enter the window)
module go_back_n_sender_window_top import gbn_pkg::*; #(
  parameter int WINDOW_MAX = 64
) (
  input wire logic  clk,
  input wire logic  rst,
  gbn_cmd_if.sink   cmd,
  gbn_res_if.source res,
  gbn_cfg_if.sink   cfg
);

  // control word from the step table, status flags back from the datapath
  ctl_word_t ctl;
  status_t   st;
  logic      go;

  // step counter and control store
  gbn_sequencer u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .ctl (ctl),
    .go  (go)
  );

  // registers, send count memory and result register
  gbn_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res),
    .cfg (cfg),
    .ctl (ctl),
    .go  (go),
    .st  (st)
  );

endmodule
`default_nettype wire
